@@ hdl/fixed_chunk_pool_allocator_defines.svh @@
// assertion macros for the chunk pool allocator
`ifndef FIXED_CHUNK_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_CHUNK_POOL_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH
// property that must hold at every clock edge outside reset
`define FCPA_CHECK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition that must be followed by another one in the next cycle
`define FCPA_CHECK_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define FCPA_CHECK(lbl, clk, rst, prop, msg)
`define FCPA_CHECK_NEXT(lbl, clk, rst, pre, post, msg)
`endif

`endif

@@ hdl/fcpa_pkg.sv @@
// shared widths, codes and reset values of the chunk pool allocator
`timescale 1ns / 1ps

package fcpa_pkg;

  // field widths
  localparam int REQ_TYPE_W     = 1;
  localparam int FREED_W        = 10;
  localparam int STATUS_W       = 2;
  localparam int CHUNK_INDEX_W  = 10;
  localparam int BLOCK_NUMBER_W = 2;
  localparam int BYTE_OFFSET_W  = 24;

  // configuration register widths
  localparam int CHUNK_BYTES_W = 16;
  localparam int CPB_W         = 9;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 16;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_CHUNK_BYTES      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHUNKS_PER_BLOCK = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ALLOW_GROW       = 2'd2;

  // register reset values
  localparam logic [CHUNK_BYTES_W-1:0] CHUNK_BYTES_RESET = 16'd64;
  localparam logic [CPB_W-1:0]         CPB_RESET         = 9'd256;
  localparam logic                     ALLOW_GROW_RESET  = 1'b1;

  // request codes
  localparam logic [REQ_TYPE_W-1:0] REQ_ALLOC = 1'b0;
  localparam logic [REQ_TYPE_W-1:0] REQ_FREE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ALLOC = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FREED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NULL  = 2'd3;

endpackage

@@ hdl/fixed_chunk_pool_allocator.sv @@
// chunk pool allocator: LIFO free list held in a link memory
//
//   channel | handshake            | beat contents
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_stall  | req_type, freed_chunk, is_null
//   out     | out_valid / out_stall| status, chunk_index, block_number,
//           |                      | byte_offset
//   cfg     | cfg_write            | cfg_index, cfg_data (write only)
//
// allocate from a non-empty list: request, head read, pop, result
// free: request, block split, block wrap, link write, result
// null free or exhausted pool: request, result; growing the pool adds a sweep that links
//   its chunks, one link write per cycle through the memory write port
// after reset the block links the first min(256, BLOCK_CHUNKS) chunks of block 0 and
//   holds in_stall high; configuration writes are taken during that time
// a stalled result stays in the output register while the next beat is taken;
//   that beat waits in its result state until the register is free
`timescale 1ns / 1ps

`include "fixed_chunk_pool_allocator_defines.svh"

module fixed_chunk_pool_allocator
  import fcpa_pkg::*;
#(
  parameter int BLOCK_CHUNKS = 256,
  parameter int MAX_BLOCKS   = 4,
  parameter int HEADER_BYTES = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  // request channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [REQ_TYPE_W-1:0]     req_type,
  input  logic [FREED_W-1:0]        freed_chunk,
  input  logic                      is_null,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [STATUS_W-1:0]       status,
  output logic [CHUNK_INDEX_W-1:0]  chunk_index,
  output logic [BLOCK_NUMBER_W-1:0] block_number,
  output logic [BYTE_OFFSET_W-1:0]  byte_offset,
  // configuration write port
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  localparam int SLOT_W = (BLOCK_CHUNKS > 1) ? $clog2(BLOCK_CHUNKS) : 1;
  localparam int BLK_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int ADDR_W = BLK_W + SLOT_W;
  localparam int LINK_W = 1 + ADDR_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int N_W    = $clog2(BLOCK_CHUNKS + 1);
  localparam int BA_W   = $clog2(MAX_BLOCKS + 1);

  // reciprocal constants, exact quotients for every freed_chunk value
  localparam int RA_SH  = FREED_W + SLOT_W;
  localparam int RA_MUL = ((1 << RA_SH) + BLOCK_CHUNKS - 1) / BLOCK_CHUNKS;
  localparam int RB_SH  = FREED_W + BLK_W;
  localparam int RB_MUL = ((1 << RB_SH) + MAX_BLOCKS - 1) / MAX_BLOCKS;

  // sequencer states
  localparam logic [2:0] S_ACT  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_DIVA = 3'd2;
  localparam logic [2:0] S_DIVB = 3'd3;
  localparam logic [2:0] S_FREE = 3'd4;
  localparam logic [2:0] S_READ = 3'd5;
  localparam logic [2:0] S_POP  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]               state;

  // configuration registers
  logic [CHUNK_BYTES_W-1:0] chunk_bytes;
  logic [CPB_W-1:0]         chunks_per_block;
  logic                     allow_grow;

  // list state
  logic [LINK_W-1:0]        head;
  logic [BA_W-1:0]          blocks_active;

  // block activation sweep
  logic [BLK_W-1:0]         act_blk;
  logic [N_W-1:0]           act_n;
  logic [N_W-1:0]           act_cnt;
  logic                     act_pop;
  logic [N_W:0]             act_cnt_inc;
  logic                     act_last;

  // block and slot split of a freed index
  logic [FREED_W-1:0]       dx;
  logic [31:0]              qa_prod;
  logic [31:0]              qa_full;
  logic [31:0]              qb_prod;
  logic [31:0]              qb_full;
  logic [FREED_W-1:0]       dx_rem;
  logic [FREED_W-1:0]       dq_new;
  logic [FREED_W-1:0]       blk_rem;

  // decoded free target and pending result
  logic [BLK_W-1:0]         blk_r;
  logic [SLOT_W-1:0]        slot_r;
  logic [STATUS_W-1:0]      res_status;
  logic [BLK_W-1:0]         res_blk;
  logic [SLOT_W-1:0]        res_slot;
  logic [31:0]              idx_full;
  logic [31:0]              off_full;

  // link memory ports
  logic [LINK_W-1:0]        link_mem [DEPTH];
  logic                     wr_en;
  logic [ADDR_W-1:0]        wr_addr;
  logic [LINK_W-1:0]        wr_data;
  logic [LINK_W-1:0]        rd_data;

  // chunk count of a new block, zero taken as one, saturated at the block size
  function automatic logic [N_W-1:0] clamp_count(input logic [CPB_W-1:0] v);
    if (v == '0) begin
      return N_W'(1);
    end else if (32'(v) > BLOCK_CHUNKS) begin
      return N_W'(BLOCK_CHUNKS);
    end else begin
      return N_W'(v);
    end
  endfunction

  assign in_stall = (state != S_IDLE);

  // sweep position
  assign act_cnt_inc = {1'b0, act_cnt} + (N_W+1)'(1);
  assign act_last    = (act_cnt_inc == {1'b0, act_n});

  // freed index over BLOCK_CHUNKS: quotient and slot remainder
  assign qa_prod = 32'(dx) * 32'(RA_MUL);
  assign qa_full = qa_prod >> RA_SH;
  assign dq_new  = qa_full[FREED_W-1:0];
  assign dx_rem  = FREED_W'(32'(dx) - qa_full * 32'(BLOCK_CHUNKS));

  // block quotient wrapped by MAX_BLOCKS
  assign qb_prod = 32'(dx) * 32'(RB_MUL);
  assign qb_full = qb_prod >> RB_SH;
  assign blk_rem = FREED_W'(32'(dx) - qb_full * 32'(MAX_BLOCKS));

  // result values of an allocation
  assign idx_full = 32'(res_blk) * BLOCK_CHUNKS + 32'(res_slot);
  assign off_full = 32'(res_slot) * (32'(chunk_bytes) + HEADER_BYTES) + HEADER_BYTES;

  // link memory write select: activation sweep or free push
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {blk_r, slot_r};
    wr_data = head;
    if (state == S_ACT) begin
      wr_en   = 1'b1;
      wr_addr = {act_blk, act_cnt[SLOT_W-1:0]};
      wr_data = act_last ? '0 : {1'b1, act_blk, act_cnt_inc[SLOT_W-1:0]};
    end else if (state == S_FREE) begin
      wr_en = 1'b1;
    end
  end

  // link memory, registered read of the head entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    if (state == S_READ) begin
      rd_data <= link_mem[head[ADDR_W-1:0]];
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_bytes      <= CHUNK_BYTES_RESET;
      chunks_per_block <= CPB_RESET;
      allow_grow       <= ALLOW_GROW_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_CHUNK_BYTES:      chunk_bytes      <= cfg_data[CHUNK_BYTES_W-1:0];
        CFG_CHUNKS_PER_BLOCK: chunks_per_block <= cfg_data[CPB_W-1:0];
        CFG_ALLOW_GROW:       allow_grow       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // output valid: set when a result is loaded, cleared when taken downstream
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && !(out_valid && out_stall)) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_ACT;
      head          <= '0;
      blocks_active <= BA_W'(1);
      act_blk       <= '0;
      act_n         <= clamp_count(CPB_RESET);
      act_cnt       <= '0;
      act_pop       <= 1'b0;
    end else begin
      unique case (state)
        // link the chunks of a new block in ascending order
        S_ACT: begin
          act_cnt <= act_cnt_inc[N_W-1:0];
          if (act_last) begin
            head  <= {1'b1, act_blk, SLOT_W'(0)};
            state <= act_pop ? S_READ : S_IDLE;
          end
        end

        // take a request beat
        S_IDLE: begin
          if (in_valid) begin
            if (req_type == REQ_FREE) begin
              if (is_null) begin
                res_status <= ST_NULL;
                state      <= S_DONE;
              end else begin
                dx    <= freed_chunk;
                state <= S_DIVA;
              end
            end else if (head[LINK_W-1]) begin
              state <= S_READ;
            end else if (!allow_grow || (32'(blocks_active) >= MAX_BLOCKS)) begin
              res_status <= ST_EMPTY;
              state      <= S_DONE;
            end else begin
              act_blk       <= blocks_active[BLK_W-1:0];
              act_n         <= clamp_count(chunks_per_block);
              act_cnt       <= '0;
              act_pop       <= 1'b1;
              blocks_active <= blocks_active + BA_W'(1);
              state         <= S_ACT;
            end
          end
        end

        // freed_chunk / BLOCK_CHUNKS: remainder is the slot
        S_DIVA: begin
          slot_r <= SLOT_W'(dx_rem);
          dx     <= dq_new;
          state  <= S_DIVB;
        end

        // block quotient wrapped by MAX_BLOCKS
        S_DIVB: begin
          blk_r <= BLK_W'(blk_rem);
          state <= S_FREE;
        end

        // push: link the chunk to the old head
        S_FREE: begin
          head       <= {1'b1, blk_r, slot_r};
          res_status <= ST_FREED;
          state      <= S_DONE;
        end

        // head entry read in flight
        S_READ: begin
          state <= S_POP;
        end

        // pop: the link of the head becomes the new head
        S_POP: begin
          head       <= rd_data;
          res_blk    <= head[ADDR_W-1:SLOT_W];
          res_slot   <= head[SLOT_W-1:0];
          res_status <= ST_ALLOC;
          state      <= S_DONE;
        end

        // load the output register once it is free
        S_DONE: begin
          if (!(out_valid && out_stall)) begin
            status <= res_status;
            if (res_status == ST_ALLOC) begin
              chunk_index  <= idx_full[CHUNK_INDEX_W-1:0];
              block_number <= BLOCK_NUMBER_W'(res_blk);
              byte_offset  <= off_full[BYTE_OFFSET_W-1:0];
            end else begin
              chunk_index  <= '0;
              block_number <= '0;
              byte_offset  <= '0;
            end
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `FCPA_CHECK(a_read_head_valid, clk, rst, (state == S_READ) |-> head[LINK_W-1], "pop of an empty list")
  `FCPA_CHECK(a_blocks_range, clk, rst, (blocks_active != '0) && (32'(blocks_active) <= MAX_BLOCKS), "active block count out of range")
  `FCPA_CHECK(a_sweep_bound, clk, rst, (state == S_ACT) |-> (act_cnt < act_n), "activation sweep past its chunk count")
  `FCPA_CHECK(a_fields_zero, clk, rst, (out_valid && (status != ST_ALLOC)) |-> ((chunk_index == '0) && (block_number == '0) && (byte_offset == '0)), "non-allocation result carries fields")
  `FCPA_CHECK_NEXT(a_accept_busy, clk, rst, in_valid && !in_stall, state != S_IDLE, "accepted beat left no work")

endmodule

@@ tb/sv/tb_fixed_chunk_pool_allocator.sv @@
// self-checking testbench for the fixed chunk pool allocator, directed table then random mix
`timescale 1ns / 1ps

module tb_fixed_chunk_pool_allocator
  import fcpa_pkg::*;
;

  localparam int BLOCK_CHUNKS  = 256;
  localparam int MAX_BLOCKS    = 4;
  localparam int HEADER_BYTES  = 8;
  localparam int TOTAL_CHUNKS  = BLOCK_CHUNKS * MAX_BLOCKS;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 300;
  localparam int LONG_HOLD     = 200;
  localparam int SHOW_LIMIT    = 10;

  typedef struct packed {
    logic [REQ_TYPE_W-1:0] req;
    logic [FREED_W-1:0]    chunk;
    logic                  nul;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       st;
    logic [CHUNK_INDEX_W-1:0]  idx;
    logic [BLOCK_NUMBER_W-1:0] blk;
    logic [BYTE_OFFSET_W-1:0]  off;
  } grant_t;

  typedef struct packed {
    req_t   rq;
    logic   typed;
    grant_t want;
  } row_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic [REQ_TYPE_W-1:0]     req_type;
  logic [FREED_W-1:0]        freed_chunk;
  logic                      is_null;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [STATUS_W-1:0]       status;
  logic [CHUNK_INDEX_W-1:0]  chunk_index;
  logic [BLOCK_NUMBER_W-1:0] block_number;
  logic [BYTE_OFFSET_W-1:0]  byte_offset;
  logic                      cfg_write;
  logic [CFG_INDEX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;

  // free list mirror and register copies
  logic                     nxt_ok [TOTAL_CHUNKS];
  logic [FREED_W-1:0]       nxt_at [TOTAL_CHUNKS];
  logic                     in_list [TOTAL_CHUNKS];
  logic                     head_ok;
  logic [FREED_W-1:0]       head_at;
  int                       blocks_up;
  logic [CHUNK_BYTES_W-1:0] cfg_chunk_bytes;
  logic [CPB_W-1:0]         cfg_cpb;
  logic                     cfg_grow;

  // chunks currently handed out, so frees stay well formed
  logic                     held [TOTAL_CHUNKS];
  logic [FREED_W-1:0]       held_q [$];

  grant_t grants_due [$];
  grant_t offered_grant;
  grant_t seen_beat;
  grant_t due_beat;
  int     bad_beats = 0;
  int     cycle_count = 0;

  // idling controls
  logic   send_gaps = 1'b1;
  logic   recv_idle_on = 1'b1;
  logic   hold_start = 1'b0;
  logic   hold_done = 1'b0;
  int     hold_count = 0;
  int     idle_left = 0;

  // directed rows, all at reset configuration
  row_t dir_rows [16] = '{
    '{'{REQ_ALLOC, 10'd0,    1'b0}, 1'b1, '{ST_ALLOC, 10'd0,    2'd0, 24'd8}},
    '{'{REQ_ALLOC, 10'h3FF,  1'b1}, 1'b1, '{ST_ALLOC, 10'd1,    2'd0, 24'd80}},
    '{'{REQ_FREE,  10'h3FF,  1'b1}, 1'b1, '{ST_NULL,  10'd0,    2'd0, 24'd0}},
    '{'{REQ_FREE,  10'h3FF,  1'b0}, 1'b1, '{ST_FREED, 10'd0,    2'd0, 24'd0}},
    '{'{REQ_ALLOC, 10'd0,    1'b0}, 1'b1, '{ST_ALLOC, 10'h3FF,  2'd3, 24'd18368}},
    '{'{REQ_FREE,  10'd0,    1'b0}, 1'b1, '{ST_FREED, 10'd0,    2'd0, 24'd0}},
    '{'{REQ_ALLOC, 10'd0,    1'b0}, 1'b1, '{ST_ALLOC, 10'd0,    2'd0, 24'd8}},
    '{'{REQ_FREE,  10'd256,  1'b0}, 1'b1, '{ST_FREED, 10'd0,    2'd0, 24'd0}},
    '{'{REQ_ALLOC, 10'd0,    1'b0}, 1'b1, '{ST_ALLOC, 10'd256,  2'd1, 24'd8}},
    '{'{REQ_FREE,  10'd1,    1'b0}, 1'b1, '{ST_FREED, 10'd0,    2'd0, 24'd0}},
    '{'{REQ_FREE,  10'd0,    1'b0}, 1'b1, '{ST_FREED, 10'd0,    2'd0, 24'd0}},
    '{'{REQ_ALLOC, 10'd0,    1'b0}, 1'b0, '{ST_ALLOC, 10'd0,    2'd0, 24'd0}},
    '{'{REQ_ALLOC, 10'd0,    1'b0}, 1'b0, '{ST_ALLOC, 10'd0,    2'd0, 24'd0}},
    '{'{REQ_ALLOC, 10'd0,    1'b0}, 1'b0, '{ST_ALLOC, 10'd0,    2'd0, 24'd0}},
    '{'{REQ_FREE,  10'd511,  1'b0}, 1'b1, '{ST_FREED, 10'd0,    2'd0, 24'd0}},
    '{'{REQ_ALLOC, 10'd0,    1'b0}, 1'b1, '{ST_ALLOC, 10'd511,  2'd1, 24'd18368}}
  };

  fixed_chunk_pool_allocator #(
    .BLOCK_CHUNKS(BLOCK_CHUNKS),
    .MAX_BLOCKS  (MAX_BLOCKS),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .freed_chunk (freed_chunk),
    .is_null     (is_null),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .chunk_index (chunk_index),
    .block_number(block_number),
    .byte_offset (byte_offset),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // link a fresh block in ascending order and point the head at its first slot
  function automatic void open_block(int blk);
    int n;
    int base;
    int s;
    n = int'(cfg_cpb);
    if (n == 0) n = 1;
    if (n > BLOCK_CHUNKS) n = BLOCK_CHUNKS;
    base = blk * BLOCK_CHUNKS;
    for (s = 0; s < n; s++) begin
      nxt_ok[base+s]  = (s + 1 < n);
      nxt_at[base+s]  = FREED_W'(base + s + 1);
      in_list[base+s] = 1'b1;
    end
    head_ok = 1'b1;
    head_at = FREED_W'(base);
  endfunction

  // expected grant for one request, updates the free list mirror
  function automatic grant_t serve_request(req_t rq);
    grant_t      g;
    int unsigned slot;
    int unsigned pitch;
    logic [FREED_W-1:0] idx;
    g = '0;
    if (rq.req == REQ_FREE) begin
      if (rq.nul) begin
        g.st = ST_NULL;
      end else begin
        nxt_ok[rq.chunk]  = head_ok;
        nxt_at[rq.chunk]  = head_at;
        in_list[rq.chunk] = 1'b1;
        head_ok = 1'b1;
        head_at = rq.chunk;
        g.st = ST_FREED;
      end
      return g;
    end
    // empty list: grow if allowed, else out of chunks
    if (!head_ok) begin
      if (!cfg_grow || blocks_up >= MAX_BLOCKS) begin
        g.st = ST_EMPTY;
        return g;
      end
      open_block(blocks_up);
      blocks_up++;
    end
    idx   = head_at;
    slot  = int'(idx) % BLOCK_CHUNKS;
    pitch = int'(cfg_chunk_bytes) + HEADER_BYTES;
    g.st  = ST_ALLOC;
    g.idx = idx;
    g.blk = BLOCK_NUMBER_W'(int'(idx) / BLOCK_CHUNKS);
    g.off = BYTE_OFFSET_W'(slot * pitch + HEADER_BYTES);
    head_ok = nxt_ok[idx];
    head_at = nxt_at[idx];
    in_list[idx] = 1'b0;
    return g;
  endfunction

  // put one request beat on the input channel and wait until it is taken
  task automatic offer(input req_t rq, input grant_t g);
    int gap;
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    req_type      <= rq.req;
    freed_chunk   <= rq.chunk;
    is_null       <= rq.nul;
    offered_grant <= g;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // predict, track handed-out chunks, then send
  task automatic issue(input req_t rq, input logic typed, input grant_t want);
    grant_t g;
    int k;
    g = serve_request(rq);
    if (g.st == ST_ALLOC && !held[g.idx]) begin
      held[g.idx] = 1'b1;
      held_q.push_back(g.idx);
    end
    if (g.st == ST_FREED && held[rq.chunk]) begin
      held[rq.chunk] = 1'b0;
      for (k = 0; k < held_q.size(); k++) begin
        if (held_q[k] == rq.chunk) begin
          held_q.delete(k);
          break;
        end
      end
    end
    offer(rq, typed ? want : g);
  endtask

  // random mix, mostly allocs and frees of chunks in hand
  task automatic run_mix(input int count, input int alloc_pct);
    req_t rq;
    int   k;
    int   roll;
    int   pick;
    for (k = 0; k < count; k++) begin
      roll     = $urandom_range(0, 99);
      rq.req   = REQ_ALLOC;
      rq.chunk = FREED_W'($urandom);
      rq.nul   = 1'($urandom);
      if (roll >= alloc_pct) begin
        rq.req = REQ_FREE;
        rq.nul = 1'b0;
        if (roll < alloc_pct + 4) begin
          // null handle
          rq.nul = 1'b1;
        end else if (roll < alloc_pct + 8) begin
          // stray free of any chunk not already on the list
          if (in_list[rq.chunk]) rq.req = REQ_ALLOC;
        end else if (held_q.size() != 0) begin
          pick     = $urandom_range(0, held_q.size() - 1);
          rq.chunk = held_q[pick];
          if (in_list[rq.chunk]) rq.req = REQ_ALLOC;
        end else begin
          rq.req = REQ_ALLOC;
        end
      end
      issue(rq, 1'b0, '0);
    end
  endtask

  // stop sending and wait until every grant is back and the block is quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (grants_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all three registers on consecutive cycles
  task automatic set_pool(input logic [CHUNK_BYTES_W-1:0] cb, input logic [CPB_W-1:0] cpb,
                          input logic grow);
    cfg_chunk_bytes = cb;
    cfg_cpb         = cpb;
    cfg_grow        = grow;
    cfg_write <= 1'b1;
    cfg_index <= CFG_CHUNK_BYTES;
    cfg_data  <= CFG_DATA_W'(cb);
    @(posedge clk);
    cfg_index <= CFG_CHUNKS_PER_BLOCK;
    cfg_data  <= CFG_DATA_W'(cpb);
    @(posedge clk);
    cfg_index <= CFG_ALLOW_GROW;
    cfg_data  <= CFG_DATA_W'(grow);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // receiver: random stall bursts, one long hold, none at the end
  always @(posedge clk) begin
    if (hold_start && !hold_done) begin
      out_stall <= 1'b1;
      hold_count++;
      if (hold_count >= LONG_HOLD) hold_done = 1'b1;
    end else if (recv_idle_on && idle_left != 0) begin
      out_stall <= 1'b1;
      idle_left--;
    end else if (recv_idle_on && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      idle_left = $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker and expectation capture on accepted request beats
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        seen_beat = '{status, chunk_index, block_number, byte_offset};
        if (grants_due.size() == 0) begin
          bad_beats++;
          if (bad_beats <= SHOW_LIMIT)
            $display("unexpected result beat: status %0d chunk %0d block %0d offset %0d",
                     seen_beat.st, seen_beat.idx, seen_beat.blk, seen_beat.off);
        end else begin
          due_beat = grants_due.pop_front();
          if (seen_beat !== due_beat) begin
            bad_beats++;
            if (bad_beats <= SHOW_LIMIT)
              $display("result mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                       due_beat.st, due_beat.idx, due_beat.blk, due_beat.off,
                       seen_beat.st, seen_beat.idx, seen_beat.blk, seen_beat.off);
          end
        end
      end
      if (in_valid && !in_stall) grants_due.push_back(offered_grant);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    req_t rq;
    logic [FREED_W-1:0] victim;
    int i;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    req_type    <= REQ_ALLOC;
    freed_chunk <= '0;
    is_null     <= 1'b0;
    cfg_write   <= 1'b0;
    cfg_index   <= CFG_CHUNK_BYTES;
    cfg_data    <= '0;
    offered_grant <= '0;

    // mirror of the reset state, block 0 already linked
    cfg_chunk_bytes = CHUNK_BYTES_RESET;
    cfg_cpb         = CPB_RESET;
    cfg_grow        = ALLOW_GROW_RESET;
    for (i = 0; i < TOTAL_CHUNKS; i++) begin
      nxt_ok[i]  = 1'b0;
      nxt_at[i]  = '0;
      in_list[i] = 1'b0;
      held[i]    = 1'b0;
    end
    blocks_up = 1;
    open_block(0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed part
    for (i = 0; i < 16; i++) issue(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);
    settle();

    // drain block 0, grow one-chunk blocks
    set_pool(CHUNK_BYTES_W'($urandom_range(1, 65535)), 9'd0, 1'b1);
    run_mix(300, 95);
    settle();

    // smallest chunk, growth off, run dry
    set_pool(16'd1, 9'd3, 1'b0);
    run_mix(100, 90);
    settle();

    // largest chunk, oversized block count saturates
    set_pool(16'hFFFF, 9'd300, 1'b1);
    run_mix(150, 80);
    settle();

    // long receiver hold while requests keep coming
    set_pool(CHUNK_BYTES_W'($urandom_range(1, 65535)), 9'd1, 1'b1);
    hold_start = 1'b1;
    run_mix(200, 60);
    settle();

    // last part without idling: exhaust every block, then a double free
    send_gaps    = 1'b0;
    recv_idle_on = 1'b0;
    set_pool(CHUNK_BYTES_W'($urandom_range(1, 65535)), 9'd256, 1'b1);
    run_mix(100, 95);
    victim   = (held_q.size() != 0) ? held_q[0] : '0;
    rq.req   = REQ_FREE;
    rq.chunk = victim;
    rq.nul   = 1'b0;
    issue(rq, 1'b0, '0);
    issue(rq, 1'b0, '0);
    rq.req = REQ_ALLOC;
    repeat (3) issue(rq, 1'b0, '0);
    settle();

    if (bad_beats == 0 && grants_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
